// ===== sv/stvg_pkg.sv =====
package stvg_pkg;

  // configuration register indexes
  typedef enum logic {
    REG_RING_COUNT   = 1'b0,
    REG_SECTOR_COUNT = 1'b1
  } cfg_reg_e;

  // which vertex of the cell goes out
  typedef enum logic [2:0] {
    PT_A    = 3'd0,  // upper ring, previous sector
    PT_B    = 3'd1,  // lower ring, this sector
    PT_C    = 3'd2,  // upper ring, this sector
    PT_D    = 3'd3,  // lower ring, previous sector
    PT_POLE = 3'd4
  } pt_e;

  // one input word
  typedef struct packed {
    logic [7:0] ring;
    logic [7:0] sector;
  } in_t;

  // one result word
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               last_vertex;
  } out_t;

  localparam logic [7:0]  MIN_COUNT   = 8'd3;
  localparam logic [7:0]  RESET_COUNT = 8'd8;

  // pi in Q30
  localparam logic [31:0] PI_Q30 = 32'hC90F_DAA2;

  // series updates after the leading term
  localparam int unsigned NUM_UPD = 7;

  // term divisors of the sine and cosine series
  localparam logic [8:0] SIN_DIV [NUM_UPD] = '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110,
                                               9'd156, 9'd210};
  localparam logic [8:0] COS_DIV [NUM_UPD] = '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90,
                                               9'd132, 9'd182};

endpackage

// ===== sv/sphere_triangle_vertex_generator.sv =====
// UV sphere cell vertex generator. A start with busy low takes one cell (ring, sector);
// the cell's three vertices (first or last ring) or six vertices (other rings) come out
// on result_o, one per cycle, each marked by res_strobe_o for a single cycle, the final
// one with last_vertex set. The receiver cannot hold results off. An accepted cell
// passes one input stage, ANGLE_BITS restoring divider stages for the four angles,
// three stages for the angle scaling, 21 stages for seven series updates (multiply,
// reciprocal multiply, correction), then sum, clamp and fold, product and rounding
// stages, the vertex buffer and the output register. The pipeline takes a new cell
// every cycle while free; sustained acceptance is limited by the single result port,
// which sends six vertices per cell (three for first and last rings). While the vertex
// buffer is still sending and a cell waits in the last stage, the whole pipeline
// holds, and busy is high whenever the input stage holds a cell during such a hold.
// Configuration may be written only while no cell is in flight.
module sphere_triangle_vertex_generator import stvg_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = 14,
  parameter int unsigned ANGLE_BITS      = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  in_t        item_i,
  output logic       res_strobe_o,
  output out_t       result_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int unsigned AB    = ANGLE_BITS;
  localparam int unsigned RW    = AB - 2;
  localparam int unsigned IP1   = AB + 1;
  localparam int unsigned IF    = AB + 25;
  localparam int unsigned NS    = AB + 29;
  localparam int unsigned SH_XZ = 60 - COORD_FRAC_BITS;
  localparam int unsigned SH_Y  = 30 - COORD_FRAC_BITS;
  localparam logic signed [15:0] POLE_Y = (COORD_FRAC_BITS >= 15) ? -16'sd32768 :
                                          16'(-(1 << COORD_FRAC_BITS));
  localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;
  // ring lane and sector lane of each point
  localparam int T_OF [4] = '{0, 1, 0, 1};
  localparam int P_OF [4] = '{2, 3, 3, 2};

  typedef struct packed {
    logic            first;
    logic            last;
    logic [3:0][1:0] quad;
  } side_t;

  function automatic logic signed [15:0] round_sat(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] half;
    mag  = v[63] ? 64'(-v) : 64'(v);
    half = (sh > 0) ? (64'd1 << (sh - 1)) : 64'd0;
    mag  = (mag + half) >> sh;
    if (v[63]) begin
      return (mag > 64'd32768) ? -16'sd32768 : 16'(64'd0 - mag);
    end
    return (mag > 64'd32767) ? 16'sd32767 : 16'(mag);
  endfunction

  logic [7:0] ring_count_q, sector_count_q;
  logic [7:0] cfg_val;
  logic [NS-1:0] v_q;
  side_t side_q [NS];
  logic adv, ld0, em_free;

  // configuration registers
  assign cfg_val = (cfg_wdata_i < MIN_COUNT) ? MIN_COUNT : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_count_q   <= RESET_COUNT;
      sector_count_q <= RESET_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_RING_COUNT:   ring_count_q   <= cfg_val;
        REG_SECTOR_COUNT: sector_count_q <= cfg_val;
      endcase
    end
  end

  // pipeline control
  assign ld0  = adv | ~v_q[0];
  assign busy = ~ld0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {(adv ? v_q[NS-2:0] : v_q[NS-1:1]), (ld0 ? start : v_q[0])};
    end
  end

  // input saturation
  logic [7:0] ring_sat, sec_sat, sec_prev;

  always_comb begin
    ring_sat = item_i.ring;
    if (ring_sat == 8'd0) ring_sat = 8'd1;
    if (ring_sat > ring_count_q) ring_sat = ring_count_q;
    sec_sat  = (item_i.sector >= sector_count_q) ? sector_count_q - 8'd1 : item_i.sector;
    sec_prev = (sec_sat == 8'd0) ? sector_count_q - 8'd1 : sec_sat - 8'd1;
  end

  // divider state, lanes: ring-1, ring, previous sector, sector
  logic [8:0]    rem_q [AB+1][4];
  logic [AB-1:0] nq_q  [AB+1][4];
  logic [8:0]    dvs   [4];

  assign dvs[0] = {ring_count_q, 1'b0};
  assign dvs[1] = {ring_count_q, 1'b0};
  assign dvs[2] = {sector_count_q, 1'b0};
  assign dvs[3] = {sector_count_q, 1'b0};

  // input stage
  always_ff @(posedge clk_i) begin
    if (ld0) begin
      rem_q[0][0] <= {1'b0, ring_sat - 8'd1};
      rem_q[0][1] <= {1'b0, ring_sat};
      rem_q[0][2] <= {sec_prev, 1'b0};
      rem_q[0][3] <= {sec_sat, 1'b0};
      nq_q[0][0]  <= {{(AB-8){1'b0}}, ring_count_q};
      nq_q[0][1]  <= {{(AB-8){1'b0}}, ring_count_q};
      nq_q[0][2]  <= {{(AB-8){1'b0}}, sector_count_q};
      nq_q[0][3]  <= {{(AB-8){1'b0}}, sector_count_q};
      side_q[0]   <= '{first: (ring_sat == 8'd1), last: (ring_sat == ring_count_q),
                       quad: '0};
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 1; i <= AB; i++) begin : g_div
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [9:0] r2, diff;
      logic       qb;
      assign r2   = {rem_q[i-1][l], nq_q[i-1][l][AB-1]};
      assign diff = r2 - {1'b0, dvs[l]};
      assign qb   = (r2 >= {1'b0, dvs[l]});
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[i][l] <= qb ? diff[8:0] : r2[8:0];
          nq_q[i][l]  <= {nq_q[i-1][l][AB-2:0], qb};
        end
      end
    end
  end

  // sideband line, quadrants joined after the divider
  side_t side_ang;
  always_comb begin
    side_ang = side_q[IP1-1];
    for (int l = 0; l < 4; l++) begin
      side_ang.quad[l] = nq_q[AB][l][AB-1:AB-2];
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[j] <= (j == IP1) ? side_ang : side_q[j-1];
      end
    end
  end

  // angle scaling to radians and square
  logic [RW+31:0] prodx_q [4];
  logic [30:0]    x_q     [4];
  logic [61:0]    x2p_q   [4];
  logic [30:0]    x3_q    [4];
  logic [31:0]    x2_q    [4];

  for (genvar l = 0; l < 4; l++) begin : g_ang
    logic [30:0] xw;
    assign xw = 31'(prodx_q[l] >> (AB - 1));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        prodx_q[l] <= nq_q[AB][l][RW-1:0] * PI_Q30;
        x_q[l]     <= xw;
        x2p_q[l]   <= xw * xw;
        x3_q[l]    <= x_q[l];
        x2_q[l]    <= 32'(x2p_q[l] >> 30);
      end
    end
  end

  // series chains: even chain sine, odd chain cosine of lane chain/2
  logic [63:0]        a_prod_q [NUM_UPD][8];
  logic signed [33:0] a_sum_q  [NUM_UPD][8];
  logic [31:0]        a_x2_q   [NUM_UPD][8];
  logic [31:0]        b_v_q    [NUM_UPD][8];
  logic [63:0]        b_pm_q   [NUM_UPD][8];
  logic signed [33:0] b_sum_q  [NUM_UPD][8];
  logic [31:0]        b_x2_q   [NUM_UPD][8];
  logic [31:0]        c_term_q [NUM_UPD][8];
  logic signed [33:0] c_sum_q  [NUM_UPD][8];
  logic [31:0]        c_x2_q   [NUM_UPD][8];

  for (genvar k = 0; k < NUM_UPD; k++) begin : g_upd
    for (genvar g = 0; g < 8; g++) begin : g_chain
      localparam logic [8:0]  DIV   = (g % 2 == 0) ? SIN_DIV[k] : COS_DIV[k];
      localparam logic [31:0] MAGIC = 32'((64'd1 << 32) / DIV);
      logic [31:0]        term_in, x2_in, v, q0, rem;
      logic signed [33:0] sum_in;
      if (k == 0) begin : g_first
        assign term_in = (g % 2 == 0) ? {1'b0, x3_q[g/2]} : 32'h4000_0000;
        assign sum_in  = '0;
        assign x2_in   = x2_q[g/2];
      end else begin : g_next
        assign term_in = c_term_q[k-1][g];
        assign sum_in  = c_sum_q[k-1][g];
        assign x2_in   = c_x2_q[k-1][g];
      end
      assign v   = 32'(a_prod_q[k][g] >> 30);
      assign q0  = 32'(b_pm_q[k][g] >> 32);
      assign rem = b_v_q[k][g] - 32'(q0 * DIV);
      always_ff @(posedge clk_i) begin
        if (adv) begin
          // accumulate and multiply by x squared
          a_prod_q[k][g] <= term_in * x2_in;
          a_sum_q[k][g]  <= (k % 2 == 1) ? sum_in - signed'({2'b00, term_in})
                                         : sum_in + signed'({2'b00, term_in});
          a_x2_q[k][g]   <= x2_in;
          // reciprocal multiply
          b_v_q[k][g]    <= v;
          b_pm_q[k][g]   <= v * MAGIC;
          b_sum_q[k][g]  <= a_sum_q[k][g];
          b_x2_q[k][g]   <= a_x2_q[k][g];
          // quotient correction
          c_term_q[k][g] <= (rem >= 32'(DIV)) ? q0 + 32'd1 : q0;
          c_sum_q[k][g]  <= b_sum_q[k][g];
          c_x2_q[k][g]   <= b_x2_q[k][g];
        end
      end
    end
  end

  // last term, clamp and quadrant fold
  logic signed [33:0] f_sum_q [8];
  logic signed [31:0] sn_q [4];
  logic signed [31:0] cs_q [4];

  for (genvar g = 0; g < 8; g++) begin : g_fin
    always_ff @(posedge clk_i) begin
      if (adv) begin
        f_sum_q[g] <= c_sum_q[NUM_UPD-1][g] - signed'({2'b00, c_term_q[NUM_UPD-1][g]});
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_fold
    logic signed [31:0] s, c;
    always_comb begin
      if (f_sum_q[2*l] > ONE_Q30) s = 32'(ONE_Q30);
      else if (f_sum_q[2*l] < -ONE_Q30) s = 32'(-ONE_Q30);
      else s = 32'(f_sum_q[2*l]);
      if (f_sum_q[2*l+1] > ONE_Q30) c = 32'(ONE_Q30);
      else if (f_sum_q[2*l+1] < -ONE_Q30) c = 32'(-ONE_Q30);
      else c = 32'(f_sum_q[2*l+1]);
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        unique case (side_q[IF].quad[l])
          2'd0: begin sn_q[l] <= s;  cs_q[l] <= c;  end
          2'd1: begin sn_q[l] <= c;  cs_q[l] <= -s; end
          2'd2: begin sn_q[l] <= -s; cs_q[l] <= -c; end
          default: begin sn_q[l] <= -c; cs_q[l] <= s; end
        endcase
      end
    end
  end

  // point products and rounding
  logic signed [63:0] px_q [4];
  logic signed [63:0] pz_q [4];
  logic signed [31:0] ct_q [2];
  logic signed [15:0] rx_q [4];
  logic signed [15:0] rz_q [4];
  logic signed [15:0] ry_q [2];

  for (genvar j = 0; j < 4; j++) begin : g_pt
    always_ff @(posedge clk_i) begin
      if (adv) begin
        px_q[j] <= cs_q[P_OF[j]] * sn_q[T_OF[j]];
        pz_q[j] <= sn_q[P_OF[j]] * sn_q[T_OF[j]];
        rx_q[j] <= round_sat(px_q[j], SH_XZ);
        rz_q[j] <= round_sat(-pz_q[j], SH_XZ);
      end
    end
  end

  for (genvar t = 0; t < 2; t++) begin : g_y
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ct_q[t] <= cs_q[t];
        ry_q[t] <= round_sat({{32{ct_q[t][31]}}, ct_q[t]}, SH_Y);
      end
    end
  end

  // vertex buffer
  logic               em_v_q;
  logic [2:0]         em_cnt_q, em_end_q;
  logic               em_last_q, em_first_q;
  logic signed [15:0] em_x_q [4];
  logic signed [15:0] em_z_q [4];
  logic signed [15:0] em_y_q [2];

  assign em_free = ~em_v_q | (em_cnt_q == em_end_q);
  assign adv     = ~v_q[NS-1] | em_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_v_q   <= 1'b0;
      em_cnt_q <= '0;
      em_end_q <= '0;
    end else if (em_free) begin
      em_v_q   <= v_q[NS-1];
      em_cnt_q <= '0;
      em_end_q <= (side_q[NS-1].first | side_q[NS-1].last) ? 3'd2 : 3'd5;
    end else begin
      em_cnt_q <= em_cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_free) begin
      em_x_q     <= rx_q;
      em_z_q     <= rz_q;
      em_y_q     <= ry_q;
      em_last_q  <= side_q[NS-1].last;
      em_first_q <= side_q[NS-1].first;
    end
  end

  // vertex order of the cell
  pt_e  pick;
  out_t res_d;
  logic [1:0] pidx;

  always_comb begin
    if (em_last_q) begin
      unique case (em_cnt_q)
        3'd0:    pick = PT_A;
        3'd1:    pick = PT_POLE;
        default: pick = PT_C;
      endcase
    end else if (em_first_q) begin
      unique case (em_cnt_q)
        3'd0:    pick = PT_A;
        3'd1:    pick = PT_D;
        default: pick = PT_B;
      endcase
    end else begin
      unique case (em_cnt_q)
        3'd0:    pick = PT_A;
        3'd1:    pick = PT_B;
        3'd2:    pick = PT_C;
        3'd3:    pick = PT_A;
        3'd4:    pick = PT_D;
        default: pick = PT_B;
      endcase
    end
    pidx = pick[1:0];
    res_d.last_vertex = (em_cnt_q == em_end_q);
    if (pick == PT_POLE) begin
      res_d.pos_x = '0;
      res_d.pos_y = POLE_Y;
      res_d.pos_z = '0;
    end else begin
      res_d.pos_x = em_x_q[pidx];
      res_d.pos_y = em_y_q[pidx[0]];
      res_d.pos_z = em_z_q[pidx];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_o <= 1'b0;
    end else begin
      res_strobe_o <= em_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_o <= res_d;
  end

endmodule

// ===== dv/tb_sphere_triangle_vertex_generator.sv =====
`timescale 1ns / 100ps

module tb_sphere_triangle_vertex_generator;
  import stvg_pkg::*;

  localparam int          LATENCY     = 16 + 31;
  localparam int          SETTLE      = LATENCY + 20;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam longint      ONE         = 64'sd1 << 30;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_t        item_i = '0;
  logic       res_strobe_o;
  out_t       result_o;
  logic       cfg_we_i = 1'b0;
  cfg_reg_e   cfg_idx_i = REG_RING_COUNT;
  logic [7:0] cfg_wdata_i = '0;

  sphere_triangle_vertex_generator uut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .res_strobe_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #4 clk_i = ~clk_i;

  // mirror of the count registers
  logic [7:0] ring_cnt = RESET_COUNT;
  logic [7:0] sector_cnt = RESET_COUNT;

  in_t         cell_q[$];
  out_t        vertex_q[$];
  logic        took;
  logic        hold_off = 1'b0;
  int unsigned gap = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // sine and cosine in Q30 of a turn fraction
  function automatic void turn_sincos(input longint unsigned a, output longint sn,
                                      output longint cs);
    longint unsigned r, x, x2, term;
    longint          s, c;
    logic [1:0]      quad;
    quad = a[15:14];
    r = a & 64'h3FFF;
    x = (r * 64'hC90F_DAA2) >> 15;
    x2 = (x * x) >> 30;
    s = 0;
    c = 0;
    term = x;
    for (int k = 0; k < 8; k++) begin
      if (k % 2) s -= longint'(term); else s += longint'(term);
      term = ((term * x2) >> 30) / longint'((2 * k + 2) * (2 * k + 3));
    end
    term = ONE;
    for (int k = 0; k < 8; k++) begin
      if (k % 2) c -= longint'(term); else c += longint'(term);
      term = ((term * x2) >> 30) / longint'((2 * k + 1) * (2 * k + 2));
    end
    if (s > ONE) s = ONE;
    if (s < -ONE) s = -ONE;
    if (c > ONE) c = ONE;
    if (c < -ONE) c = -ONE;
    case (quad)
      2'd0: begin sn = s; cs = c; end
      2'd1: begin sn = c; cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic longint unsigned turn_of(longint unsigned k, longint unsigned den);
    return ((k << 17) + den) / (2 * den);
  endfunction

  // round half away from zero, then saturate to 16 bits
  function automatic logic signed [15:0] to_fixed(longint v, int sh);
    longint unsigned m;
    longint          r;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    r = (v < 0) ? -longint'(m) : longint'(m);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic out_t vertex(longint st, longint ct, longint sp, longint cp);
    out_t v;
    v.pos_x = to_fixed(cp * st, 46);
    v.pos_y = to_fixed(ct, 16);
    v.pos_z = to_fixed(-(sp * st), 46);
    v.last_vertex = 1'b0;
    return v;
  endfunction

  // expected vertices of one cell
  function automatic void predict_cell(in_t c);
    longint unsigned rc, sc, ring, sec, prev;
    longint          st0, ct0, st1, ct1, sp0, cp0, sp1, cp1;
    out_t            v[$];
    out_t            pole;
    rc = ring_cnt;
    sc = sector_cnt;
    ring = c.ring;
    sec = c.sector;
    if (ring < 1) ring = 1;
    if (ring > rc) ring = rc;
    if (sec >= sc) sec = sc - 1;
    prev = (sec == 0) ? sc - 1 : sec - 1;
    turn_sincos(turn_of(ring - 1, 2 * rc), st0, ct0);
    turn_sincos(turn_of(ring, 2 * rc), st1, ct1);
    turn_sincos(turn_of(prev, sc), sp0, cp0);
    turn_sincos(turn_of(sec, sc), sp1, cp1);
    if (ring == rc) begin
      pole = '0;
      pole.pos_y = to_fixed(-ONE, 16);
      v = {v, vertex(st0, ct0, sp0, cp0)};
      v = {v, pole};
      v = {v, vertex(st0, ct0, sp1, cp1)};
    end else begin
      if (ring != 1) begin
        v = {v, vertex(st0, ct0, sp0, cp0)};
        v = {v, vertex(st1, ct1, sp1, cp1)};
        v = {v, vertex(st0, ct0, sp1, cp1)};
      end
      v = {v, vertex(st0, ct0, sp0, cp0)};
      v = {v, vertex(st1, ct1, sp0, cp0)};
      v = {v, vertex(st1, ct1, sp1, cp1)};
    end
    v[v.size() - 1].last_vertex = 1'b1;
    vertex_q = {vertex_q, v};
  endfunction

  // driver: one cell word per start, random gap after each
  always @(negedge clk_i) begin
    if (rst_ni && !(start && !took)) begin
      if (gap > 0) begin
        start <= 1'b0;
        gap <= gap - 1;
      end else if (cell_q.size() > 0 && !hold_off) begin
        item_i <= cell_q.pop_front();
        start <= 1'b1;
        gap <= $urandom_range(0, 4);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on accept, check each vertex word
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    took <= start && !busy && rst_ni;
    if (rst_ni && start && !busy) predict_cell(item_i);
    if (rst_ni && res_strobe_o) begin
      if (vertex_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected vertex %p", result_o);
      end else if (result_o !== vertex_q[0]) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("vertex mismatch exp %p got %p", vertex_q[0], result_o);
        void'(vertex_q.pop_front());
      end else begin
        void'(vertex_q.pop_front());
      end
    end
  end

  task automatic drain();
    wait (cell_q.size() == 0 && !start && vertex_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    if (idx == REG_RING_COUNT) ring_cnt = (data < MIN_COUNT) ? MIN_COUNT : data;
    else sector_cnt = (data < MIN_COUNT) ? MIN_COUNT : data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_cell(logic [7:0] r, logic [7:0] s);
    in_t word;
    word.ring = r;
    word.sector = s;
    cell_q = {cell_q, word};
  endtask

  // mostly in-range cells, some anywhere in the field
  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8)
        add_cell(8'($urandom_range(1, ring_cnt)), 8'($urandom_range(0, sector_cnt - 1)));
      else
        add_cell(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset counts, edges of ring and sector
    add_cell(8'd0, 8'd0);
    add_cell(8'd1, 8'd3);
    add_cell(8'd2, 8'd7);
    add_cell(8'd7, 8'd8);
    add_cell(8'd8, 8'd0);
    add_cell(8'd9, 8'd255);
    add_cell(8'd255, 8'd1);
    add_cell(8'd4, 8'd0);
    drain();

    // small count writes clamp to the minimum
    write_reg(REG_RING_COUNT, 8'd0);
    write_reg(REG_SECTOR_COUNT, 8'd2);
    add_cell(8'd1, 8'd0);
    add_cell(8'd2, 8'd2);
    add_cell(8'd3, 8'd1);
    add_cell(8'd200, 8'd170);
    add_random(30);
    drain();

    // largest counts
    write_reg(REG_RING_COUNT, 8'd255);
    write_reg(REG_SECTOR_COUNT, 8'd255);
    add_cell(8'd1, 8'd254);
    add_cell(8'd128, 8'd0);
    add_cell(8'd254, 8'd127);
    add_cell(8'd255, 8'd255);
    add_random(60);

    // hold off until the pipeline has emptied
    wait (cell_q.size() < 30);
    hold_off = 1'b1;
    wait (!start && vertex_q.size() == 0);
    hold_off = 1'b0;
    drain();

    // random count settings
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_RING_COUNT, 8'($urandom_range(0, 40)));
      write_reg(REG_SECTOR_COUNT, (p == 5) ? 8'hFF : 8'($urandom_range(0, 64)));
      add_random(50);
      drain();
    end

    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
